FILE: hw/rtl/cursor_unique_set_list_defines.svh
// Assertion macros shared by the cursor_unique_set_list RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CURSOR_UNIQUE_SET_LIST_DEFINES_SVH
`define CURSOR_UNIQUE_SET_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CULS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CULS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/culs_pkg.sv
// Types and constants for the cursor_unique_set_list block.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package culs_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 32;
	localparam int REQ_W    = 3;
	localparam int STS_W    = 3;
	localparam int LEN_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FWD    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_GET    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SET    = 3'd5;

	localparam logic [STS_W-1:0] ST_DONE   = 3'd0;
	localparam logic [STS_W-1:0] ST_FULL   = 3'd1;
	localparam logic [STS_W-1:0] ST_DUP    = 3'd2;
	localparam logic [STS_W-1:0] ST_NOELEM = 3'd3;
	localparam logic [STS_W-1:0] ST_BOUND  = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE,
		OP_WRITE,
		OP_FWD,
		OP_BACK
	} op_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_ENTRY,
		RD_ONES
	} rd_sel_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [VAL_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [STS_W-1:0] status;
		logic [LEN_W-1:0] list_length;
		logic [LEN_W-1:0] cursor_position;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic             capture;
		logic             commit;
		op_t              op;
		rd_sel_t          rd_sel;
		logic [STS_W-1:0] status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic dup;
		logic at_end;
		logic at_zero;
	} sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/culs_ctrl.sv
// Request controller: accepts a request, decides the operation and status.
// Depends on culs_pkg and cursor_unique_set_list_defines.svh.
`default_nettype none
`include "cursor_unique_set_list_defines.svh"

module culs_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [culs_pkg::REQ_W-1:0] req_type,
	input  wire culs_pkg::sts_t            sts,
	output culs_pkg::cmd_t                 cmd,
	output logic                           busy,
	output logic                           done
);
	import culs_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t           state_q;
	logic             done_q;
	logic [REQ_W-1:0] req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			req_q   <= REQ_ADD;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						req_q   <= req_type;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.op      = OP_NONE;
		cmd.rd_sel  = RD_ZERO;
		cmd.status  = ST_DONE;
		cmd.capture = (state_q == S_IDLE) && start;
		if (state_q == S_EXEC) begin
			cmd.commit = 1'b1;
			unique case (req_q)
				REQ_ADD: begin
					if (sts.full)
						cmd.status = ST_FULL;
					else if (sts.dup)
						cmd.status = ST_DUP;
					else
						cmd.op = OP_INSERT;
				end
				REQ_REMOVE: begin
					if (sts.at_end)
						cmd.status = ST_NOELEM;
					else
						cmd.op = OP_REMOVE;
				end
				REQ_FWD: begin
					if (sts.at_end)
						cmd.status = ST_BOUND;
					else
						cmd.op = OP_FWD;
				end
				REQ_BACK: begin
					if (sts.at_zero)
						cmd.status = ST_BOUND;
					else
						cmd.op = OP_BACK;
				end
				REQ_GET: begin
					if (sts.at_end) begin
						cmd.status = ST_NOELEM;
						cmd.rd_sel = RD_ONES;
					end else begin
						cmd.rd_sel = RD_ENTRY;
					end
				end
				REQ_SET: begin
					if (sts.at_end)
						cmd.status = ST_NOELEM;
					else if (sts.dup)
						cmd.status = ST_DUP;
					else
						cmd.op = OP_WRITE;
				end
				default: begin
					cmd.op = OP_NONE;
				end
			endcase
		end
	end

	assign busy = (state_q == S_EXEC);
	assign done = done_q;

	`CULS_ASSERT_NEXT(a_exec_then_done, clk, arst_n, state_q == S_EXEC, done_q, "no result after exec")
	`CULS_ASSERT_NOW(a_done_in_idle, clk, arst_n, done_q, state_q == S_IDLE, "result while busy")
	`CULS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done_q, "accept not taken")

endmodule

`default_nettype wire

FILE: hw/rtl/culs_dpath.sv
// Datapath: row of entry cells with parallel compare and shift, length, cursor, result.
// Depends on culs_pkg and cursor_unique_set_list_defines.svh.
`default_nettype none
`include "cursor_unique_set_list_defines.svh"

module culs_dpath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [culs_pkg::VAL_W-1:0] value,
	input  wire culs_pkg::cmd_t            cmd,
	output culs_pkg::sts_t                 sts,
	output culs_pkg::result_t              result
);
	import culs_pkg::*;

	logic [VAL_W-1:0] entries_q [CAPACITY];
	logic [VAL_W-1:0] entries_d [CAPACITY];
	logic [VAL_W-1:0] up        [CAPACITY];
	logic [VAL_W-1:0] down      [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic [VAL_W-1:0] value_q;
	logic [CNT_W-1:0] length_q;
	logic [CNT_W-1:0] cursor_q;
	logic [CNT_W-1:0] length_d;
	logic [CNT_W-1:0] cursor_d;
	logic [CNT_W-1:0] len_m1;
	logic [VAL_W-1:0] cur_entry;
	result_t          result_q;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_row
		if (g > 0) begin : g_up
			assign up[g] = entries_q[g-1];
		end else begin : g_up0
			assign up[g] = value_q;
		end
		if (g < CAPACITY - 1) begin : g_dn
			assign down[g] = entries_q[g+1];
		end else begin : g_dnl
			assign down[g] = entries_q[g];
		end
		assign match[g] = (entries_q[g] == value_q) && (CNT_W'(g) < length_q);
	end

	assign sts.full    = (length_q == CNT_W'(CAPACITY));
	assign sts.dup     = |match;
	assign sts.at_end  = (cursor_q >= length_q);
	assign sts.at_zero = (cursor_q == '0);

	assign len_m1    = length_q - CNT_W'(1);
	assign cur_entry = entries_q[cursor_q[IDX_W-1:0]];

	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			entries_d[k] = entries_q[k];
			if (cmd.commit) begin
				unique case (cmd.op)
					OP_INSERT: begin
						if (CNT_W'(k) == cursor_q)
							entries_d[k] = value_q;
						else if (CNT_W'(k) > cursor_q && CNT_W'(k) <= length_q)
							entries_d[k] = up[k];
					end
					OP_REMOVE: begin
						if (CNT_W'(k) >= cursor_q && CNT_W'(k) < len_m1)
							entries_d[k] = down[k];
					end
					OP_WRITE: begin
						if (CNT_W'(k) == cursor_q)
							entries_d[k] = value_q;
					end
					default: begin
						entries_d[k] = entries_q[k];
					end
				endcase
			end
		end
	end

	always_comb begin
		length_d = length_q;
		cursor_d = cursor_q;
		if (cmd.commit) begin
			unique case (cmd.op)
				OP_INSERT: length_d = length_q + CNT_W'(1);
				OP_REMOVE: length_d = len_m1;
				OP_FWD:    cursor_d = cursor_q + CNT_W'(1);
				OP_BACK:   cursor_d = cursor_q - CNT_W'(1);
				default:   length_d = length_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			cursor_q <= '0;
		end else begin
			length_q <= length_d;
			cursor_q <= cursor_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CAPACITY; k++)
			entries_q[k] <= entries_d[k];
		if (cmd.capture)
			value_q <= value;
		if (cmd.commit) begin
			unique case (cmd.rd_sel)
				RD_ENTRY: result_q.read_value <= cur_entry;
				RD_ONES:  result_q.read_value <= '1;
				default:  result_q.read_value <= '0;
			endcase
			result_q.status          <= cmd.status;
			result_q.list_length     <= LEN_W'(length_d);
			result_q.cursor_position <= LEN_W'(cursor_d);
		end
	end

	assign result = result_q;

	`CULS_ASSERT_NOW(a_cur_le_len, clk, arst_n, 1'b1, cursor_q <= length_q, "cursor past length")
	`CULS_ASSERT_NOW(a_len_le_cap, clk, arst_n, 1'b1, length_q <= CNT_W'(CAPACITY), "length over capacity")
	`CULS_ASSERT_NOW(a_insert_room, clk, arst_n, cmd.commit && cmd.op == OP_INSERT, !sts.full && !sts.dup, "insert refused case taken")

endmodule

`default_nettype wire

FILE: hw/rtl/cursor_unique_set_list.sv
// Top level of the bounded ordered unique-value list with cursor.
// Depends on culs_pkg, culs_ctrl and culs_dpath.
//
// Usage:
//   A request (request.req_type, request.value) is taken at a rising edge
//   where start is high and busy is low. Request types: add, remove,
//   forward, backward, get, set; codes 6 and 7 are ignored (status done).
//   Each request yields exactly one result on result, marked by done for
//   one cycle. The receiver cannot stall; a result not sampled is lost.
// Operation:
//   The accept edge latches the request. In the exec cycle that follows,
//   the value is compared against every live cell in parallel, and the
//   shift/write commits at the next edge, which also registers the result.
//   done rises at that same edge. busy is high for the one exec cycle, so
//   a new request can be taken as soon as busy falls, including in the
//   cycle in which done is high. The compare-and-shift across the
//   16-cell row is done in parallel within the exec cycle.
// Reset: arst_n low empties the list and puts the cursor at 0; entry
//   contents stay undefined until written.
`default_nettype none

module cursor_unique_set_list (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire culs_pkg::request_t request,
	output logic                    busy,
	output logic                    done,
	output culs_pkg::result_t       result
);
	import culs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	culs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (request.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	culs_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (request.value),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

`default_nettype wire
